/* sv/pttm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the pose to TRS matrix block.
// No dependencies; imported by pose_to_trs_matrices and pttm_checker.
package pttm_pkg;

  // Quotient bits kept by the divider lanes before the final rounding step.
  localparam int unsigned QBITS            = 34;
  localparam int unsigned DIV_BITS_PER_STG = 2;
  localparam int unsigned DIV_STAGES       = QBITS / DIV_BITS_PER_STG;

  // Row sequencing: three forward rows, then three inverse rows.
  localparam logic [2:0] ROWS_PER_MAT = 3'd3;
  localparam logic [2:0] ROW_LAST     = 3'd5;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic {
    MAT_FWD = 1'b0,
    MAT_INV = 1'b1
  } mat_e;

  // Per-row control and forward results that travel along the row pipeline.
  typedef struct packed {
    mat_e             which;
    logic [1:0]       row;
    logic             last;
    logic             zs;     // inverse row with zero scale divisor
    logic             fsat;   // forward row clamped
    logic [3:0]       neg;    // quotient sign per divider lane
    logic [3:0]       ovf;    // quotient too large per divider lane
    logic [3:0][31:0] fent;   // forward entries
  } row_tag_t;

endpackage

/* sv/pose_to_trs_matrices.sv */
`timescale 1ns / 1ps
// Top level: pose to forward and inverse 3x4 transform rows.
// Depends on pttm_pkg.
//
// Each accepted pose (position, Q2.14-style quaternion, per-axis scale) yields
// six row transfers: forward T*R*S rows 0..2, then inverse S^-1*R^T*T^-1 rows
// 0..2, the last one flagged with last_row_o. The single result channel carries one
// row per cycle when the receiver does not stall; a new pose is taken in the cycle
// its predecessor issues its sixth row. Rows move through a stall-able pipeline:
// rotation products, rotation rounding, row multiplies, row sums and magnitudes,
// divider setup, then a divider of DIV_STAGES stages retiring two quotient bits
// each, and the output register. Entries saturate to 32 bits with saturated_o; an
// inverse row whose scale is zero comes out as all zeros with zero_scale_o set.
module pose_to_trs_matrices
  import pttm_pkg::*;
#(
  parameter int unsigned POS_FRAC_BITS  = 16,
  parameter int unsigned QUAT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               which_matrix_o,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] entry_c0_o,
  output logic signed [31:0] entry_c1_o,
  output logic signed [31:0] entry_c2_o,
  output logic signed [31:0] entry_c3_o,
  output logic               saturated_o,
  output logic               zero_scale_o,
  output logic               last_row_o
);

  localparam int PF    = int'(POS_FRAC_BITS);
  localparam int QF    = int'(QUAT_FRAC_BITS);
  localparam int PR_W  = 33;                                   // 2*a*b
  localparam int RF_W  = ((2 * QF > 33) ? 2 * QF : 33) + 2;    // exact rotation
  localparam int RQ_W  = RF_W + 1 - QF;                        // rounded rotation
  localparam int FM_W  = RQ_W + 32;                            // row product
  localparam int FR_W  = FM_W + 1 - QF;                        // rounded fwd entry
  localparam int NS_W  = FM_W + 2;                             // sum of three
  localparam int E1    = 2 * PF - QF + 1;
  localparam int E2    = PF - QF + 1;
  localparam int A1    = (E1 > 0) ? E1 : 0;
  localparam int B1    = (E1 < 0) ? -E1 : 0;
  localparam int A2    = (E2 > 0) ? E2 : 0;
  localparam int B2    = (E2 < 0) ? -E2 : 0;
  localparam int NUM1_W = RQ_W + A1;
  localparam int NUM2_W = NS_W + A2;
  localparam int NUM_W0 = (NUM1_W > NUM2_W) ? NUM1_W : NUM2_W;
  localparam int NUM_W  = (NUM_W0 > int'(QBITS)) ? NUM_W0 : int'(QBITS) + 1;
  localparam int HI_W   = NUM_W - int'(QBITS);
  localparam int BMAX   = (B1 > B2) ? B1 : B2;
  localparam int DEN_W  = 32 + BMAX;
  localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;

  localparam logic signed [RF_W-1:0] ONE_RF = RF_W'(1) << (2 * QF);
  localparam logic signed [RF_W:0]   HALF_R = (RF_W + 1)'(1) << (QF - 1);
  localparam logic signed [FM_W:0]   HALF_F = (FM_W + 1)'(1) << (QF - 1);
  localparam logic [QBITS-1:0]       Q_HALF = QBITS'(64'h8000_0000);
  localparam logic [QBITS-1:0]       Q_MAXP = QBITS'(64'h7fff_ffff);

  function automatic logic signed [PR_W-1:0] dmul(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    logic signed [31:0] m;
    m = a * b;
    return {m, 1'b0};
  endfunction

  function automatic logic [DEN_W-1:0] den_of(input logic trans, input logic [31:0] d);
    if (trans) return DEN_W'(d) << B2;
    return DEN_W'(d) << B1;
  endfunction

  logic out_vld_q;
  logic adv;
  assign adv = !out_vld_q || !out_stall_i;

  // ---------------------------------------------------------------- hold
  logic              hold_vld_q;
  logic [2:0]        hold_cnt_q;
  logic signed [31:0] hold_p_q [3];
  logic signed [31:0] hold_s_q [3];
  logic signed [15:0] hold_qx_q, hold_qy_q, hold_qz_q, hold_qw_q;
  logic              in_xfer, issue;
  row_tag_t          hold_tag;

  assign in_stall_o = hold_vld_q && !(adv && (hold_cnt_q == ROW_LAST));
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign issue      = hold_vld_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      hold_cnt_q <= '0;
    end else if (in_xfer) begin
      hold_vld_q <= 1'b1;
      hold_cnt_q <= '0;
    end else if (issue) begin
      if (hold_cnt_q == ROW_LAST) hold_vld_q <= 1'b0;
      else hold_cnt_q <= hold_cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hold_p_q[0] <= pos_x_i;
      hold_p_q[1] <= pos_y_i;
      hold_p_q[2] <= pos_z_i;
      hold_s_q[0] <= scale_x_i;
      hold_s_q[1] <= scale_y_i;
      hold_s_q[2] <= scale_z_i;
      hold_qx_q   <= quat_x_i;
      hold_qy_q   <= quat_y_i;
      hold_qz_q   <= quat_z_i;
      hold_qw_q   <= quat_w_i;
    end
  end

  // Row being issued from the held pose
  always_comb begin
    hold_tag      = '0;
    hold_tag.last = (hold_cnt_q == ROW_LAST);
    if (hold_cnt_q >= ROWS_PER_MAT) begin
      hold_tag.which = MAT_INV;
      hold_tag.row   = 2'(hold_cnt_q - ROWS_PER_MAT);
    end else begin
      hold_tag.which = MAT_FWD;
      hold_tag.row   = 2'(hold_cnt_q);
    end
  end

  // ---------------------------------------------------------------- S1: quaternion products
  logic               s1_vld_q;
  row_tag_t           s1_tag_q;
  logic signed [31:0] s1_p_q [3];
  logic signed [31:0] s1_s_q [3];
  logic signed [PR_W-1:0] s1_xx_q, s1_yy_q, s1_zz_q, s1_xy_q, s1_xz_q;
  logic signed [PR_W-1:0] s1_yz_q, s1_wx_q, s1_wy_q, s1_wz_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q <= hold_tag;
      s1_p_q   <= hold_p_q;
      s1_s_q   <= hold_s_q;
      s1_xx_q  <= dmul(hold_qx_q, hold_qx_q);
      s1_yy_q  <= dmul(hold_qy_q, hold_qy_q);
      s1_zz_q  <= dmul(hold_qz_q, hold_qz_q);
      s1_xy_q  <= dmul(hold_qx_q, hold_qy_q);
      s1_xz_q  <= dmul(hold_qx_q, hold_qz_q);
      s1_yz_q  <= dmul(hold_qy_q, hold_qz_q);
      s1_wx_q  <= dmul(hold_qw_q, hold_qx_q);
      s1_wy_q  <= dmul(hold_qw_q, hold_qy_q);
      s1_wz_q  <= dmul(hold_qw_q, hold_qz_q);
    end
  end

  // ---------------------------------------------------------------- S2: rotation, rounded
  logic signed [RF_W-1:0] rf_d [3][3];
  logic signed [RF_W:0]   rt_d [3][3];
  logic signed [RQ_W-1:0] s2_rq_q [3][3];
  logic signed [RQ_W-1:0] s2_rq_d [3][3];
  logic               s2_vld_q;
  row_tag_t           s2_tag_q;
  logic signed [31:0] s2_p_q [3];
  logic signed [31:0] s2_s_q [3];

  always_comb begin
    rf_d[0][0] = ONE_RF - (RF_W'(s1_yy_q) + RF_W'(s1_zz_q));
    rf_d[0][1] = RF_W'(s1_xy_q) - RF_W'(s1_wz_q);
    rf_d[0][2] = RF_W'(s1_xz_q) + RF_W'(s1_wy_q);
    rf_d[1][0] = RF_W'(s1_xy_q) + RF_W'(s1_wz_q);
    rf_d[1][1] = ONE_RF - (RF_W'(s1_xx_q) + RF_W'(s1_zz_q));
    rf_d[1][2] = RF_W'(s1_yz_q) - RF_W'(s1_wx_q);
    rf_d[2][0] = RF_W'(s1_xz_q) - RF_W'(s1_wy_q);
    rf_d[2][1] = RF_W'(s1_yz_q) + RF_W'(s1_wx_q);
    rf_d[2][2] = ONE_RF - (RF_W'(s1_xx_q) + RF_W'(s1_yy_q));
    // round half up to QF fraction bits
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rt_d[i][j]    = (RF_W + 1)'(rf_d[i][j]) + HALF_R;
        s2_rq_d[i][j] = rt_d[i][j][RF_W:QF];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_tag_q <= s1_tag_q;
      s2_p_q   <= s1_p_q;
      s2_s_q   <= s1_s_q;
      s2_rq_q  <= s2_rq_d;
    end
  end

  // ---------------------------------------------------------------- S3: row multiplies
  // Forward lane j: Rq(r,j)*s_j. Inverse lane k: Rq(k,r)*p_k.
  logic signed [RQ_W-1:0] op_a [3];
  logic signed [31:0]     op_b [3];
  logic signed [FM_W-1:0] s3_mp_d [3];
  logic signed [FM_W-1:0] s3_mp_q [3];
  logic signed [RQ_W-1:0] s3_col_d [3];
  logic signed [RQ_W-1:0] s3_col_q [3];
  logic               s3_vld_q;
  row_tag_t           s3_tag_q;
  logic signed [31:0] s3_pr_q, s3_sr_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (s2_tag_q.which == MAT_INV) begin
        op_a[j] = s2_rq_q[j][s2_tag_q.row];
        op_b[j] = s2_p_q[j];
      end else begin
        op_a[j] = s2_rq_q[s2_tag_q.row][j];
        op_b[j] = s2_s_q[j];
      end
      s3_col_d[j] = s2_rq_q[j][s2_tag_q.row];
      s3_mp_d[j]  = op_a[j] * op_b[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_tag_q <= s2_tag_q;
      s3_mp_q  <= s3_mp_d;
      s3_col_q <= s3_col_d;
      s3_pr_q  <= s2_p_q[s2_tag_q.row];
      s3_sr_q  <= s2_s_q[s2_tag_q.row];
    end
  end

  // ---------------------------------------------------------------- S4: forward finish, inverse magnitudes
  logic signed [FM_W:0]   t_f [3];
  logic signed [FR_W-1:0] fr_v [3];
  logic signed [NS_W-1:0] n_sum;
  row_tag_t               s4_tag_d, s4_tag_q;
  logic [RQ_W-1:0]        s4_cmag_d [3];
  logic [RQ_W-1:0]        s4_cmag_q [3];
  logic [NS_W-1:0]        s4_nmag_d, s4_nmag_q;
  logic [31:0]            s4_d_d, s4_d_q;
  logic                   s4_vld_q;
  logic                   s_neg;

  always_comb begin
    s4_tag_d = s3_tag_q;
    s_neg    = s3_sr_q[31];
    // forward entries: round half up, then clamp
    for (int j = 0; j < 3; j++) begin
      t_f[j]  = (FM_W + 1)'(s3_mp_q[j]) + HALF_F;
      fr_v[j] = t_f[j][FM_W:QF];
      if (fr_v[j] > FR_W'(S32_MAX)) begin
        s4_tag_d.fent[j] = S32_MAX;
        s4_tag_d.fsat    = 1'b1;
      end else if (fr_v[j] < FR_W'(S32_MIN)) begin
        s4_tag_d.fent[j] = S32_MIN;
        s4_tag_d.fsat    = 1'b1;
      end else begin
        s4_tag_d.fent[j] = fr_v[j][31:0];
      end
    end
    s4_tag_d.fent[3] = s3_pr_q;
    // inverse: numerator magnitudes and quotient signs
    n_sum = NS_W'(s3_mp_q[0]) + NS_W'(s3_mp_q[1]) + NS_W'(s3_mp_q[2]);
    for (int j = 0; j < 3; j++) begin
      s4_cmag_d[j]    = s3_col_q[j][RQ_W-1] ? RQ_W'(-s3_col_q[j]) : RQ_W'(s3_col_q[j]);
      s4_tag_d.neg[j] = s3_col_q[j][RQ_W-1] ^ s_neg;
    end
    s4_nmag_d       = n_sum[NS_W-1] ? NS_W'(-n_sum) : NS_W'(n_sum);
    s4_tag_d.neg[3] = (n_sum > 0) ^ s_neg;   // numerator is -N
    s4_d_d          = s_neg ? 32'(-s3_sr_q) : 32'(s3_sr_q);
    s4_tag_d.zs     = (s3_tag_q.which == MAT_INV) && (s3_sr_q == 32'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_tag_q  <= s4_tag_d;
      s4_cmag_q <= s4_cmag_d;
      s4_nmag_q <= s4_nmag_d;
      s4_d_q    <= s4_d_d;
    end
  end

  // ---------------------------------------------------------------- divider lanes
  // Lanes 0..2: column entries, lane 3: translation. Stage 0 aligns and checks
  // for a quotient of 2^QBITS or more; each later stage retires two bits.
  logic [DEN_W-1:0] dv_rem_d [DIV_STAGES+1][4];
  logic [DEN_W-1:0] dv_rem_q [DIV_STAGES+1][4];
  logic [QBITS-1:0] dv_nlo_d [DIV_STAGES+1][4];
  logic [QBITS-1:0] dv_nlo_q [DIV_STAGES+1][4];
  logic [QBITS-1:0] dv_quo_d [DIV_STAGES+1][4];
  logic [QBITS-1:0] dv_quo_q [DIV_STAGES+1][4];
  logic [31:0]      dv_d_d   [DIV_STAGES+1];
  logic [31:0]      dv_d_q   [DIV_STAGES+1];
  row_tag_t         dv_tag_d [DIV_STAGES+1];
  row_tag_t         dv_tag_q [DIV_STAGES+1];
  logic [DIV_STAGES:0] dv_vld_q;

  logic [NUM_W-1:0] num0 [4];
  logic [DEN_W-1:0] den0 [4];
  logic [HI_W-1:0]  hi0  [4];

  always_comb begin
    dv_tag_d[0] = s4_tag_q;
    dv_d_d[0]   = s4_d_q;
    for (int l = 0; l < 4; l++) begin
      if (l == 3) num0[l] = NUM_W'(s4_nmag_q) << A2;
      else        num0[l] = NUM_W'(s4_cmag_q[l]) << A1;
      den0[l]              = den_of(l == 3, s4_d_q);
      hi0[l]               = num0[l][NUM_W-1:QBITS];
      dv_tag_d[0].ovf[l]   = CMP_W'(hi0[l]) >= CMP_W'(den0[l]);
      dv_rem_d[0][l]       = DEN_W'(hi0[l]);
      dv_nlo_d[0][l]       = num0[l][QBITS-1:0];
      dv_quo_d[0][l]       = '0;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    always_comb begin
      logic [DEN_W-1:0] rem;
      logic [DEN_W:0]   t;
      logic [QBITS-1:0] nlo;
      logic [QBITS-1:0] quo;
      logic [DEN_W-1:0] den;
      dv_tag_d[k] = dv_tag_q[k-1];
      dv_d_d[k]   = dv_d_q[k-1];
      for (int l = 0; l < 4; l++) begin
        rem = dv_rem_q[k-1][l];
        nlo = dv_nlo_q[k-1][l];
        quo = dv_quo_q[k-1][l];
        den = den_of(l == 3, dv_d_q[k-1]);
        for (int b = 0; b < int'(DIV_BITS_PER_STG); b++) begin
          t   = {rem, nlo[QBITS-1]};
          nlo = {nlo[QBITS-2:0], 1'b0};
          if (t >= {1'b0, den}) begin
            rem = DEN_W'(t - {1'b0, den});
            quo = {quo[QBITS-2:0], 1'b1};
          end else begin
            rem = t[DEN_W-1:0];
            quo = {quo[QBITS-2:0], 1'b0};
          end
        end
        dv_rem_d[k][l] = rem;
        dv_nlo_d[k][l] = nlo;
        dv_quo_d[k][l] = quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem_q <= dv_rem_d;
      dv_nlo_q <= dv_nlo_d;
      dv_quo_q <= dv_quo_d;
      dv_d_q   <= dv_d_d;
      dv_tag_q <= dv_tag_d;
    end
  end

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= hold_vld_q;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      dv_vld_q  <= {dv_vld_q[DIV_STAGES-1:0], s4_vld_q};
      out_vld_q <= dv_vld_q[DIV_STAGES];
    end
  end

  // ---------------------------------------------------------------- final rounding and output register
  row_tag_t          ft;
  logic [QBITS:0]    q_inc [4];
  logic [QBITS-1:0]  q_r   [4];
  logic [31:0]       inv_ent [4];
  logic [3:0]        inv_sat;
  logic [31:0]       fin_ent_d [4];
  logic              fin_sat_d, fin_zs_d;
  logic [31:0]       out_ent_q [4];
  mat_e              out_which_q;
  logic [1:0]        out_row_q;
  logic              out_sat_q, out_zs_q, out_last_q;

  always_comb begin
    ft = dv_tag_q[DIV_STAGES];
    for (int l = 0; l < 4; l++) begin
      q_inc[l]   = {1'b0, dv_quo_q[DIV_STAGES][l]} + (QBITS + 1)'(1);
      q_r[l]     = q_inc[l][QBITS:1];
      inv_sat[l] = 1'b0;
      if (ft.ovf[l]) begin
        inv_sat[l] = 1'b1;
        inv_ent[l] = ft.neg[l] ? S32_MIN : S32_MAX;
      end else if (ft.neg[l]) begin
        if (q_r[l] > Q_HALF) begin
          inv_sat[l] = 1'b1;
          inv_ent[l] = S32_MIN;
        end else begin
          inv_ent[l] = 32'(-q_r[l][31:0]);
        end
      end else if (q_r[l] > Q_MAXP) begin
        inv_sat[l] = 1'b1;
        inv_ent[l] = S32_MAX;
      end else begin
        inv_ent[l] = q_r[l][31:0];
      end
    end
    // row selection: forward, zero scale, or divided
    fin_zs_d = 1'b0;
    if (ft.which == MAT_FWD) begin
      for (int l = 0; l < 4; l++) fin_ent_d[l] = ft.fent[l];
      fin_sat_d = ft.fsat;
    end else if (ft.zs) begin
      for (int l = 0; l < 4; l++) fin_ent_d[l] = '0;
      fin_sat_d = 1'b0;
      fin_zs_d  = 1'b1;
    end else begin
      fin_ent_d = inv_ent;
      fin_sat_d = |inv_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ent_q   <= fin_ent_d;
      out_which_q <= ft.which;
      out_row_q   <= ft.row;
      out_sat_q   <= fin_sat_d;
      out_zs_q    <= fin_zs_d;
      out_last_q  <= ft.last;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign which_matrix_o = out_which_q;
  assign row_index_o    = out_row_q;
  assign entry_c0_o     = out_ent_q[0];
  assign entry_c1_o     = out_ent_q[1];
  assign entry_c2_o     = out_ent_q[2];
  assign entry_c3_o     = out_ent_q[3];
  assign saturated_o    = out_sat_q;
  assign zero_scale_o   = out_zs_q;
  assign last_row_o     = out_last_q;

  // ---------------------------------------------------------------- assertions
  a_hold_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_vld_q && (hold_cnt_q != ROW_LAST)) |-> in_stall_o)
    else $error("new pose taken while rows of the held pose remain");

  a_load_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (hold_vld_q && (hold_cnt_q == 3'd0)))
    else $error("pose transfer did not restart the row count");

  a_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && last_row_o) |-> ((out_which_q == MAT_INV) && (row_index_o == 2'd2)))
    else $error("last row flag on a row other than inverse row 2");

  a_zero_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && zero_scale_o) |-> (!saturated_o && (out_which_q == MAT_INV) &&
      (entry_c0_o == 32'sd0) && (entry_c3_o == 32'sd0)))
    else $error("zero scale row with nonzero entries or clamp flag");

endmodule

/* sim/pttm_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for pose_to_trs_matrices: watches both channels, predicts rows.
// Depends on pttm_pkg.
module pttm_checker
  import pttm_pkg::*;
(
  input  logic               clk_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               which_matrix_i,
  input  logic [1:0]         row_index_i,
  input  logic signed [31:0] entry_c0_i,
  input  logic signed [31:0] entry_c1_i,
  input  logic signed [31:0] entry_c2_i,
  input  logic signed [31:0] entry_c3_i,
  input  logic               saturated_i,
  input  logic               zero_scale_i,
  input  logic               last_row_i,
  output int                 fail_count_o,
  output int                 rows_pending_o
);

  localparam int PF = 16;
  localparam int QF = 14;

  typedef struct packed {
    mat_e              which;
    logic [1:0]        row;
    logic [3:0][31:0]  ent;
    logic              sat;
    logic              zs;
    logic              last;
  } xform_row_t;

  xform_row_t row_queue[$];
  int         fails_q = 0;

  assign fail_count_o   = fails_q;
  assign rows_pending_o = row_queue.size();

  // floor((v + 2^(n-1)) / 2^n)
  function automatic longint round_shr(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [31:0] sat32(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // round(num * 2^e / den), ties away from zero, clamped; 128-bit exact
  function automatic logic [31:0] scaled_quot(longint num, longint den, int e,
                                              inout logic sat);
    logic signed [127:0] n, d, q, r, mag;
    logic neg;
    n = num;
    d = den;
    if (e >= 0) n = n <<< e;
    else d = d <<< (-e);
    neg = (n < 0) != (d < 0);
    if (n < 0) n = -n;
    if (d < 0) d = -d;
    q = n / d;
    r = n % d;
    mag = (2 * r >= d) ? q + 1 : q;
    return sat32(neg ? -mag : mag, sat);
  endfunction

  task automatic predict_pose();
    longint p[3], s[3], rf[3][3], rq[3][3], nsum;
    longint x, y, z, w, one;
    xform_row_t t;
    x = quat_x_i; y = quat_y_i; z = quat_z_i; w = quat_w_i;
    p[0] = pos_x_i; p[1] = pos_y_i; p[2] = pos_z_i;
    s[0] = scale_x_i; s[1] = scale_y_i; s[2] = scale_z_i;
    one = longint'(1) <<< (2 * QF);
    rf[0][0] = one - 2*(y*y + z*z); rf[0][1] = 2*(x*y - w*z); rf[0][2] = 2*(x*z + w*y);
    rf[1][0] = 2*(x*y + w*z); rf[1][1] = one - 2*(x*x + z*z); rf[1][2] = 2*(y*z - w*x);
    rf[2][0] = 2*(x*z - w*y); rf[2][1] = 2*(y*z + w*x); rf[2][2] = one - 2*(x*x + y*y);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) rq[i][j] = round_shr(rf[i][j], QF);
    for (int rr = 0; rr < 6; rr++) begin
      t = '0;
      t.which = (rr >= 3) ? MAT_INV : MAT_FWD;
      t.row = 2'(rr % 3);
      t.last = (rr == 5);
      if (rr < 3) begin
        for (int j = 0; j < 3; j++) t.ent[j] = sat32(round_shr(rq[rr][j] * s[j], QF), t.sat);
        t.ent[3] = p[rr][31:0];
      end else if (s[rr-3] == 0) begin
        t.zs = 1'b1;
      end else begin
        nsum = 0;
        for (int j = 0; j < 3; j++)
          t.ent[j] = scaled_quot(rq[j][rr-3], s[rr-3], 2*PF - QF, t.sat);
        for (int k = 0; k < 3; k++) nsum += rq[k][rr-3] * p[k];
        t.ent[3] = scaled_quot(-nsum, s[rr-3], PF - QF, t.sat);
      end
      row_queue.push_back(t);
    end
  endtask

  // Predict on input transfer, compare on output transfer
  always @(posedge clk_i) begin
    xform_row_t want, got;
    if (in_valid_i && !in_stall_i) predict_pose();
    if (out_valid_i && !out_stall_i) begin
      got.which = mat_e'(which_matrix_i);
      got.row = row_index_i;
      got.ent = {entry_c3_i, entry_c2_i, entry_c1_i, entry_c0_i};
      got.sat = saturated_i;
      got.zs = zero_scale_i;
      got.last = last_row_i;
      if (row_queue.size() == 0) begin
        $display("%0t: unexpected row transfer, expected none, actual %h", $time, got);
        fails_q <= fails_q + 1;
      end else begin
        want = row_queue.pop_front();
        if (got !== want) begin
          $display("%0t: row mismatch, expected %h, actual %h", $time, want, got);
          fails_q <= fails_q + 1;
        end
      end
    end
  end

endmodule

/* sim/tb_pose_to_trs_matrices.sv */
`timescale 1ns / 1ps
// Testbench top for pose_to_trs_matrices: directed and random poses, random gaps.
// Depends on pttm_checker and the block.
module tb_pose_to_trs_matrices;

  localparam int WATCHDOG = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b1;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] qx = '0, qy = '0, qz = '0, qw = '0;
  logic signed [31:0] sx = '0, sy = '0, sz = '0;
  logic which_m, sat_f, zs_f, last_f;
  logic [1:0] row_idx;
  logic signed [31:0] e0, e1, e2, e3;
  int fails, pending;
  int idle_pct = 35;
  bit hold_off = 0;
  int quiet = 0;

  always #6 clk_i = ~clk_i;

  pose_to_trs_matrices DUT (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz), .quat_w_i(qw),
    .scale_x_i(sx), .scale_y_i(sy), .scale_z_i(sz),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .which_matrix_o(which_m), .row_index_o(row_idx),
    .entry_c0_o(e0), .entry_c1_o(e1), .entry_c2_o(e2), .entry_c3_o(e3),
    .saturated_o(sat_f), .zero_scale_o(zs_f), .last_row_o(last_f)
  );

  pttm_checker u_checker (
    .clk_i, .in_valid_i(in_valid), .in_stall_i(in_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .quat_x_i(qx), .quat_y_i(qy), .quat_z_i(qz), .quat_w_i(qw),
    .scale_x_i(sx), .scale_y_i(sy), .scale_z_i(sz),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .which_matrix_i(which_m), .row_index_i(row_idx),
    .entry_c0_i(e0), .entry_c1_i(e1), .entry_c2_i(e2), .entry_c3_i(e3),
    .saturated_i(sat_f), .zero_scale_i(zs_f), .last_row_i(last_f),
    .fail_count_o(fails), .rows_pending_o(pending)
  );

  // Receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One pose transfer, with a random gap first; valid stays up until the next call
  task automatic send_pose(logic [31:0] px, py, pz, logic [15:0] ax, ay, az, aw,
                           logic [31:0] kx, ky, kz);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    qx <= ax; qy <= ay; qz <= az; qw <= aw;
    sx <= kx; sy <= ky; sz <= kz;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(5))
      0: return 32'(signed'($urandom_range(3 << 16))) * ($urandom_range(1) ? 1 : -1);
      1: return 32'd0;
      2: return 32'd1 << $urandom_range(30);
      3: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    return $urandom_range(2) == 0 ? $urandom() : 32'(signed'($urandom_range(1 << 22)) - (1 << 21));
  endfunction

  function automatic logic [15:0] rand_quat();
    return $urandom_range(2) == 0 ? 16'($urandom()) : 16'($urandom_range(32767) - 16384);
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // Directed: identity, extremes, zero and negative scale, unnormalized quat
    send_pose(32'h0001_0000, 32'hffff_0000, 32'h0, 16'h0, 16'h0, 16'h0, 16'h4000,
              32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_pose(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'h7fff, 16'h8000, 16'h7fff,
              16'h8000, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
    send_pose(32'h1234_5678, 32'h0, 32'h8000_0000, 16'h2d41, 16'h0, 16'h0, 16'h2d41,
              32'h0, 32'h0, 32'h0);
    send_pose(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 32'hffff_ffff, 32'h1, 32'hffff_0000);
    send_pose(32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 16'h2000, 16'h2000,
              16'h2000, 16'h2000, 32'hfffe_0000, 32'h0000_8000, 32'h0);
    send_pose(32'hffff_ffff, 32'h1, 32'h1, 16'hffff, 16'h1, 16'h0, 16'h0,
              32'h1, 32'h8000_0000, 32'h7fff_ffff);
    send_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0,
              32'h0001_0000, 32'h0, 32'h0002_0000);
    // Long receiver hold-off while poses keep coming
    hold_off = 1;
    fork
      begin repeat (150) @(negedge clk_i); hold_off = 0; end
      repeat (12) send_pose(rand_pos(), rand_pos(), rand_pos(), rand_quat(), rand_quat(),
                            rand_quat(), rand_quat(), rand_scale(), rand_scale(), rand_scale());
    join
    // Random, with a stretch of no idling
    for (int n = 0; n < 160; n++) begin
      idle_pct = (n >= 60 && n < 100) ? 0 : 35;
      send_pose(rand_pos(), rand_pos(), rand_pos(), rand_quat(), rand_quat(),
                rand_quat(), rand_quat(), rand_scale(), rand_scale(), rand_scale());
    end
    in_valid <= 1'b0;
    idle_pct = 35;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/pttm_pkg.sv
sv/pose_to_trs_matrices.sv
sim/pttm_checker.sv
sim/tb_pose_to_trs_matrices.sv
